// ----- rtl/gmm_pkg.sv -----
`timescale 1ns / 1ps

package gmm_pkg;

	localparam int FIELD_W  = 32;
	localparam int ROWNUM_W = 5;

	// one loaded row pair, classified by the front end
	typedef struct packed {
		logic               last;
		logic [FIELD_W-1:0] first_row;
		logic [FIELD_W-1:0] second_row;
	} gmm_item_t;

	// head of the request queue as seen by the back end
	typedef struct packed {
		logic      valid;
		gmm_item_t item;
	} gmm_req_t;

endpackage

// ----- rtl/gf2_matrix_multiply.sv -----
`timescale 1ns / 1ps
// after the last row pair of a run is taken, the sequencer enters its emit state, and the
// first product row passes the first-matrix memory read and the product register; the rest
// follow one per cycle, read through the single read port of the first-matrix memory
// busy rises only when the two-entry request queue is full
// reset clears the row counters, queue and sequencer; the row stores keep old contents
// the receiver cannot stall: each product row is valid for exactly one strobe cycle

module gf2_matrix_multiply #(
	parameter int DIM = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [gmm_pkg::FIELD_W-1:0]   first_row,
	input  logic [gmm_pkg::FIELD_W-1:0]   second_row,
	output logic                          strobe,
	output logic [gmm_pkg::FIELD_W-1:0]   product_row,
	output logic [gmm_pkg::ROWNUM_W-1:0]  row_number,
	output logic                          last_row
);

	logic               push;
	logic               full;
	logic               pop;
	gmm_pkg::gmm_item_t push_item;
	gmm_pkg::gmm_req_t  head;

	assign busy = full;

	gmm_front #(
		.DIM(DIM)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.full      (full),
		.first_row (first_row),
		.second_row(second_row),
		.push      (push),
		.push_item (push_item)
	);

	gmm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.full     (full),
		.head     (head)
	);

	gmm_back #(
		.DIM(DIM)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.pop        (pop),
		.strobe     (strobe),
		.product_row(product_row),
		.row_number (row_number),
		.last_row   (last_row)
	);

endmodule

// ----- rtl/gmm_ram.sv -----
`timescale 1ns / 1ps

module gmm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/gmm_front.sv -----
`timescale 1ns / 1ps

module gmm_front #(
	parameter int DIM = 32
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              full,
	input  logic [gmm_pkg::FIELD_W-1:0]       first_row,
	input  logic [gmm_pkg::FIELD_W-1:0]       second_row,
	output logic                              push,
	output gmm_pkg::gmm_item_t                push_item
);

	localparam int CW = $clog2(DIM);

	logic [CW-1:0] load_count_q;
	logic          is_last;

	assign push    = start & ~full;
	assign is_last = (load_count_q == CW'(DIM - 1));

	always_comb begin
		push_item.last       = is_last;
		push_item.first_row  = first_row;
		push_item.second_row = second_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_count_q <= '0;
		end else if (push) begin
			load_count_q <= is_last ? '0 : load_count_q + CW'(1);
		end
	end

endmodule

// ----- rtl/gmm_queue.sv -----
`timescale 1ns / 1ps

module gmm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  gmm_pkg::gmm_item_t  push_item,
	input  logic                pop,
	output logic                full,
	output gmm_pkg::gmm_req_t   head
);

	gmm_pkg::gmm_item_t ent_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               do_pop;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.item  = ent_q[rd_ptr_q];
	assign do_pop     = pop & head.valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- rtl/gmm_back.sv -----
`timescale 1ns / 1ps

module gmm_back #(
	parameter int DIM = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  gmm_pkg::gmm_req_t                  head,
	output logic                               pop,
	output logic                               strobe,
	output logic [gmm_pkg::FIELD_W-1:0]        product_row,
	output logic [gmm_pkg::ROWNUM_W-1:0]       row_number,
	output logic                               last_row
);

	localparam int AW   = $clog2(DIM);
	localparam int SDIM = (DIM < gmm_pkg::FIELD_W) ? DIM : gmm_pkg::FIELD_W;
	localparam logic [gmm_pkg::FIELD_W-1:0] COL_MASK =
		(DIM >= gmm_pkg::FIELD_W) ? {gmm_pkg::FIELD_W{1'b1}} :
		((gmm_pkg::FIELD_W'(1) << DIM) - gmm_pkg::FIELD_W'(1));

	typedef enum logic [2:0] {
		ST_LOAD  = 3'b001,
		ST_EMIT  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t                      state_q;
	logic [AW-1:0]               wr_idx_q;
	logic [AW-1:0]               rd_idx_q;
	logic [AW-1:0]               idx_s1;
	logic                        valid_s1;
	logic                        rd_en;
	logic                        do_pop;
	logic [gmm_pkg::FIELD_W-1:0] first_rd;
	logic [gmm_pkg::FIELD_W-1:0] second_q [SDIM];
	logic [gmm_pkg::FIELD_W-1:0] prod_next;

	logic                          strobe_q;
	logic [gmm_pkg::FIELD_W-1:0]   product_q;
	logic [gmm_pkg::ROWNUM_W-1:0]  row_q;
	logic                          last_q;

	// stores are only written between runs, so reads never race a write
	assign pop    = (state_q == ST_LOAD);
	assign do_pop = pop & head.valid;
	assign rd_en  = (state_q == ST_EMIT);

	gmm_ram #(
		.WIDTH(gmm_pkg::FIELD_W),
		.DEPTH(DIM)
	) u_first_ram (
		.clk  (clk),
		.we   (do_pop),
		.waddr(wr_idx_q),
		.wdata(head.item.first_row),
		.re   (rd_en),
		.raddr(rd_idx_q),
		.rdata(first_rd)
	);

	// only the low rows of the second matrix can be selected
	always_ff @(posedge clk) begin
		for (int j = 0; j < SDIM; j++) begin
			if (do_pop && wr_idx_q == AW'(j)) begin
				second_q[j] <= head.item.second_row;
			end
		end
	end

	always_comb begin
		logic [gmm_pkg::FIELD_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < SDIM; k++) begin
			if (first_rd[k]) begin
				acc = acc ^ second_q[k];
			end
		end
		prod_next = acc & COL_MASK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_LOAD;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			unique case (state_q)
				ST_LOAD: begin
					if (do_pop) begin
						if (head.item.last) begin
							wr_idx_q <= '0;
							rd_idx_q <= '0;
							state_q  <= ST_EMIT;
						end else begin
							wr_idx_q <= wr_idx_q + AW'(1);
						end
					end
				end
				ST_EMIT: begin
					if (rd_idx_q == AW'(DIM - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_LOAD;
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			idx_s1 <= rd_idx_q;
		end
		product_q <= prod_next;
		row_q     <= gmm_pkg::ROWNUM_W'(idx_s1);
		last_q    <= (idx_s1 == AW'(DIM - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_s1;
		end
	end

	assign strobe      = strobe_q;
	assign product_row = product_q;
	assign row_number  = row_q;
	assign last_row    = last_q & strobe_q;

endmodule

// ----- rtl/gmm_checker.sv -----
`timescale 1ns / 1ps

module gmm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          busy,
	input logic                          strobe,
	input logic [gmm_pkg::ROWNUM_W-1:0]  row_number,
	input logic                          last_row
);

	// rows of one run come out back to back and in order
	a_rows_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last_row |=> strobe &&
			(row_number == gmm_pkg::ROWNUM_W'($past(row_number) + 1'b1)))
		else $error("product rows not consecutive");

	a_last_marked: assert property (@(posedge clk) disable iff (!arst_n)
		last_row |-> strobe)
		else $error("last_row without strobe");

	// a new run needs at least one request popped before emitting
	a_gap_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last_row |=> !strobe)
		else $error("strobe right after last row");

	a_run_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(strobe) |-> row_number == '0)
		else $error("run does not start at row zero");

	a_busy_after_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !busy)
		else $error("busy right after reset");

endmodule

bind gf2_matrix_multiply gmm_checker u_gmm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.busy      (busy),
	.strobe    (strobe),
	.row_number(row_number),
	.last_row  (last_row)
);
